>>> sv/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// shared constants, state encoding and controller/datapath link types for
// the two-way lru write-through cache
// ----------------------------------------------------------------------------
package lruc_pkg;

   // geometry
   localparam int NUM_SETS   = 16;
   localparam int LINE_BYTES = 32;
   localparam int MEM_BYTES  = 4096;

   // fixed field widths
   localparam int ADDR_W    = 12;
   localparam int DATA_W    = 8;
   localparam int CNT_W     = 32;
   localparam int PCT_W     = 7;
   localparam int PCT_SCALE = 100;

   // derived widths
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int SET_W  = $clog2(NUM_SETS);
   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int TAG_W  = MEM_AW - OFF_W - SET_W;
   localparam int NUM_W  = CNT_W + PCT_W;
   localparam int STEP_W = $clog2(PCT_W);

   // stream payload widths
   localparam int REQ_FIELDS_W = ADDR_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + DATA_W + CNT_W + CNT_W + PCT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      REQ_READ  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic ready;
      logic accept;
      logic clear_we;
      logic lookup;
      logic mul;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

>>> sv/lruc_ram.sv
// ----------------------------------------------------------------------------
// lruc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lruc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lruc_ctrl.sv
// ----------------------------------------------------------------------------
// lruc_ctrl
// sequencer: memory clear after reset, then accept, lookup, multiply,
// divide steps and result load for one word at a time
// ----------------------------------------------------------------------------
module lruc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  lruc_pkg::status_type status,
   output lruc_pkg::cmd_type    cmd
);
   import lruc_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              last_step;

   assign last_step = (step_ff == STEP_W'(PCT_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (last_step) state_in = ST_OUT;
         ST_OUT:    if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_we = 1'b1;
         ST_IDLE: begin
            cmd.ready  = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_LOOKUP: cmd.lookup   = 1'b1;
         ST_MUL:    cmd.mul      = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_OUT:    cmd.load_out = status.out_free;
         default:   cmd = '0;
      endcase
   end

   // divide step count
   always_comb begin
      step_in = step_ff;
      if (cmd.mul) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !cmd.ready || $past(status.clear_last))
      else $error("word accepted before memory clear finished");

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && $past(state_ff) == ST_DIV) |-> $past(last_step))
      else $error("divide left before all quotient bits");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free && !cmd.ready)
      else $error("result loaded into busy output register");

endmodule

>>> sv/lruc_dp.sv
// ----------------------------------------------------------------------------
// lruc_dp
// datapath: backing memory, tag/valid/lru arrays, saturating counters,
// miss percentage multiply and restoring divide, output register
// ----------------------------------------------------------------------------
module lruc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  lruc_pkg::cmd_type               cmd,
   output lruc_pkg::status_type            status,
   input  lruc_pkg::req_kind_type          req_kind,
   input  logic [lruc_pkg::ADDR_W-1:0]     req_addr,
   input  logic [lruc_pkg::DATA_W-1:0]     req_wdata,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [lruc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lruc_pkg::*;

   // memory addressing
   logic [MEM_AW-1:0] mem_addr;
   logic [MEM_AW-1:0] clr_cnt_ff;
   logic [MEM_AW-1:0] clr_cnt_in;
   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic [DATA_W-1:0] ram_rdata;

   // accepted word
   logic             is_write_ff;
   logic [SET_W-1:0] set_ff;
   logic [TAG_W-1:0] tag_ff;

   // cache arrays
   logic [NUM_SETS-1:0][1:0] valid_ff;
   logic [NUM_SETS-1:0][1:0] valid_in;
   logic [NUM_SETS-1:0]      lru_ff;
   logic [NUM_SETS-1:0]      lru_in;
   logic [TAG_W-1:0]         tag0_ff [NUM_SETS];
   logic [TAG_W-1:0]         tag1_ff [NUM_SETS];

   // lookup
   logic       hit0;
   logic       hit1;
   logic       hit;
   logic       fill;
   logic       victim;
   logic [1:0] set_valid;

   // counters and result fields
   logic [CNT_W-1:0]  access_ff;
   logic [CNT_W-1:0]  access_in;
   logic [CNT_W-1:0]  miss_ff;
   logic [CNT_W-1:0]  miss_in;
   logic              hit_ff;
   logic [DATA_W-1:0] rdata_ff;

   // divider
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] rem_in;
   logic [NUM_W-1:0] dsh_ff;
   logic [NUM_W-1:0] dsh_in;
   logic [PCT_W-1:0] quo_ff;
   logic [PCT_W-1:0] quo_in;
   logic             fits;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   assign mem_addr = MEM_AW'(req_addr);

   // clear sweep, then write-through on accepted writes
   assign ram_we    = cmd.clear_we || (cmd.accept && req_kind == REQ_WRITE);
   assign ram_waddr = cmd.clear_we ? clr_cnt_ff : mem_addr;
   assign ram_wdata = cmd.clear_we ? '0 : req_wdata;
   assign clr_cnt_in = cmd.clear_we ? clr_cnt_ff + MEM_AW'(1) : clr_cnt_ff;

   assign status.clear_last = (clr_cnt_ff == '1);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   lruc_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MEM_BYTES)
   ) u_mem (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(mem_addr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_write_ff <= (req_kind == REQ_WRITE);
         set_ff      <= mem_addr[OFF_W +: SET_W];
         tag_ff      <= mem_addr[MEM_AW-1 -: TAG_W];
      end
   end

   // tag compare and replacement choice
   assign set_valid = valid_ff[set_ff];
   assign hit0   = set_valid[0] && (tag0_ff[set_ff] == tag_ff);
   assign hit1   = set_valid[1] && (tag1_ff[set_ff] == tag_ff);
   assign hit    = hit0 || hit1;
   assign fill   = !hit && !is_write_ff;
   assign victim = !set_valid[0] ? 1'b0 : (!set_valid[1] ? 1'b1 : lru_ff[set_ff]);

   always_comb begin
      valid_in  = valid_ff;
      lru_in    = lru_ff;
      access_in = access_ff;
      miss_in   = miss_ff;
      if (cmd.lookup) begin
         if (access_ff != '1) access_in = access_ff + CNT_W'(1);
         if (!hit && miss_ff != '1) miss_in = miss_ff + CNT_W'(1);
         if (hit) begin
            lru_in[set_ff] = hit0;
         end else if (fill) begin
            valid_in[set_ff][victim] = 1'b1;
            lru_in[set_ff]           = !victim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         lru_ff    <= '0;
         access_ff <= '0;
         miss_ff   <= '0;
      end else begin
         valid_ff  <= valid_in;
         lru_ff    <= lru_in;
         access_ff <= access_in;
         miss_ff   <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup && fill && !victim) begin
         tag0_ff[set_ff] <= tag_ff;
      end
      if (cmd.lookup && fill && victim) begin
         tag1_ff[set_ff] <= tag_ff;
      end
      if (cmd.lookup) begin
         hit_ff   <= hit;
         rdata_ff <= (hit && !is_write_ff) ? ram_rdata : '0;
      end
   end

   // miss * 100 / access, one quotient bit per step, msb first
   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (cmd.mul) begin
         rem_in = NUM_W'(miss_ff) * NUM_W'(PCT_SCALE);
         dsh_in = NUM_W'(access_ff) << (PCT_W - 1);
         quo_in = '0;
      end else if (cmd.div_step) begin
         if (fits) rem_in = rem_ff - dsh_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[PCT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= RSP_TDATA_W'({quo_ff, access_ff, miss_ff, rdata_ff, hit_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_miss_le_access: assert property (@(posedge clock) disable iff (reset)
      miss_ff <= access_ff)
      else $error("miss count above access count");

   a_one_way_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |-> !(hit0 && hit1))
      else $error("same tag valid in both ways");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.lookup |=> $stable(valid_ff))
      else $error("valid bits changed outside lookup");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> quo_ff <= PCT_W'(PCT_SCALE))
      else $error("miss percentage above 100");

endmodule

>>> sv/two_way_lru_write_through_cache.sv
// ----------------------------------------------------------------------------
// two_way_lru_write_through_cache
// two-way set-associative lru cache in front of a byte memory, write-through
// with no allocate on write miss; every word returns hit, read byte, saturating
// miss and access counts and the integer miss percentage
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: req_type; tdata: addr, wdata
//   rsp      out  rsp_tvalid/rsp_tready  tdata: hit, rdata, miss_total,
//                                               access_total, miss_percent
//
// after reset the backing memory is swept to zero, one byte a cycle, with
// req_tready low
// each word then passes accept, tag lookup, multiply, 7 restoring divide
// steps for the percentage and load into the result register; a new word is
// taken only once the last one is loaded, and the output register lets the
// next word in while the last result still waits
// reset is synchronous, active high, and clears all control state, the valid and lru bits and the counters
//
module two_way_lru_write_through_cache (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,  // [0] req_type (0 read, 1 write)
   input  logic [lruc_pkg::REQ_TDATA_W-1:0] req_tdata,  // [11:0] addr, [19:12] wdata
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] hit, [8:1] rdata, [40:9] miss_total, [72:41] access_total,
   // [79:73] miss_percent
   output logic [lruc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lruc_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_kind_type req_kind;

   // unpack request word
   assign req_kind = req_kind_type'(req_tuser);

   // controller drives ready only in its idle state
   assign req_tready = cmd.ready;

   lruc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .status    (status),
      .cmd       (cmd)
   );

   lruc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_kind  (req_kind),
      .req_addr  (req_tdata[ADDR_W-1:0]),
      .req_wdata (req_tdata[ADDR_W +: DATA_W]),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata)
   );

endmodule
